### hw/rtl/rrs_pkg.sv
// Shared types and constants of the ROI radiometric statistics core.
package rrs_pkg;

   localparam int ROW_W      = 9;
   localparam int COL_W      = 10;
   localparam int CNT_W      = 16;
   localparam int COEF_W     = 32;
   localparam int SCALE_W    = 24;
   localparam int RAD_W      = 48;
   localparam int SUM_W      = 64;
   localparam int NPIX_W     = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // calibration datapath widths
   localparam int PROD_W = COEF_W + CNT_W + 1;   // gain*count+offset, signed
   localparam int VLO_W  = 25;                   // low unsigned slice of v
   localparam int VHI_W  = PROD_W - VLO_W;       // high signed slice of v
   localparam int FULL_W = PROD_W + SCALE_W;     // v*scale, signed
   localparam int Q_W    = FULL_W - 16;          // floor(v*scale/2^16)
   localparam int QS_W   = 42;                   // q once known inside the limit

   localparam int QUEUE_DEPTH = 4;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_MEASURE = 1'b1;

   localparam logic [ROW_W-1:0]   ROI_TOP_RST    = 9'd0;
   localparam logic [COL_W-1:0]   ROI_LEFT_RST   = 10'd0;
   localparam logic [ROW_W-1:0]   ROI_BOTTOM_RST = 9'd511;
   localparam logic [COL_W-1:0]   ROI_RIGHT_RST  = 10'd1023;
   localparam logic [SCALE_W-1:0] SCALE_RST      = 24'd65536;

   localparam logic signed [RAD_W-1:0] RAD_MAX   = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [RAD_W-1:0] RAD_MIN   = 48'sh8000_0000_0000;
   localparam logic signed [RAD_W-1:0] RAD_SCALE = 48'sd100;
   localparam logic signed [Q_W-1:0]   Q_LIMIT   = 57'sd1407374883553;
   localparam logic signed [SUM_W-1:0] SUM_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN   = 64'sh8000_0000_0000_0000;
   localparam logic [NPIX_W-1:0]       COUNT_MAX = 20'hF_FFFF;
   // magnitude limits of the mean before it is narrowed to 48 bits
   localparam logic [SUM_W-1:0] MEAN_POS_LIM = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [SUM_W-1:0] MEAN_NEG_LIM = 64'h0000_8000_0000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROI_TOP    = 3'd0,
      CSR_ROI_LEFT   = 3'd1,
      CSR_ROI_BOTTOM = 3'd2,
      CSR_ROI_RIGHT  = 3'd3,
      CSR_SCALE      = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_FIN,
      DIV_SHOW
   } div_state_type;

   typedef struct packed {
      logic [ROW_W-1:0]   roi_top;
      logic [COL_W-1:0]   roi_left;
      logic [ROW_W-1:0]   roi_bottom;
      logic [COL_W-1:0]   roi_right;
      logic [SCALE_W-1:0] scale_factor;
   } cfg_type;

   typedef struct packed {
      logic                     is_measure;
      logic                     in_array;
      logic                     in_roi;
      logic                     last;
      logic [ROW_W-1:0]         row;
      logic [COL_W-1:0]         col;
      logic [CNT_W-1:0]         pixel_count;
      logic signed [COEF_W-1:0] gain;
      logic signed [COEF_W-1:0] offset;
      logic                     coeff_valid;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic take;
   } ctl_type;

   typedef struct packed {
      logic signed [RAD_W-1:0] max_radiance;
      logic signed [SUM_W-1:0] sum_radiance;
      logic [NPIX_W-1:0]       valid_pixels;
   } stats_type;

endpackage

### hw/rtl/rrs_req_if.sv
// Input channel: load and measure beats.
interface rrs_req_if;
   logic                              valid;
   logic                              ready;
   logic                              op;
   logic [rrs_pkg::ROW_W-1:0]         row;
   logic [rrs_pkg::COL_W-1:0]         col;
   logic [rrs_pkg::CNT_W-1:0]         pixel_count;
   logic signed [rrs_pkg::COEF_W-1:0] gain;
   logic signed [rrs_pkg::COEF_W-1:0] offset;
   logic                              coeff_valid;
   logic                              last;

   modport source (output valid, op, row, col, pixel_count, gain, offset, coeff_valid, last,
                   input ready);
   modport sink   (input valid, op, row, col, pixel_count, gain, offset, coeff_valid, last,
                   output ready);
endinterface

### hw/rtl/rrs_rsp_if.sv
// Result channel: region statistics beats.
interface rrs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [rrs_pkg::RAD_W-1:0] max_radiance;
   logic signed [rrs_pkg::RAD_W-1:0] mean_radiance;
   logic signed [rrs_pkg::SUM_W-1:0] sum_radiance;
   logic [rrs_pkg::NPIX_W-1:0]       valid_pixels;

   modport source (output valid, max_radiance, mean_radiance, sum_radiance, valid_pixels,
                   input ready);
   modport sink   (input valid, max_radiance, mean_radiance, sum_radiance, valid_pixels,
                   output ready);
endinterface

### hw/rtl/rrs_csr_if.sv
// Configuration write channel.
interface rrs_csr_if;
   logic                             valid;
   logic                             ready;
   logic [rrs_pkg::CSR_IDX_W-1:0]    index;
   logic [rrs_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/roi_radiometric_statistics_core.sv
// Top level of the ROI radiometric statistics core.
// Load beats write one pixel's gain, offset and valid mark into the
// coefficient tables; measure beats calibrate one raw count and fold the
// radiance into running maximum, sum and count when the pixel lies in the
// region and its coefficients are valid. Beats of either kind are taken one
// per clock into a four-entry queue while it is not full; the back end pops
// one a cycle while the queue holds beats into a seven-stage calibration
// pipeline (table read, gain multiply, offset add, split scale multiply,
// shift and saturate, times 100, accumulate). A last pixel hands the
// statistics to a restoring divider that produces the mean one bit per
// cycle; the result is registered in a finishing state and held until
// taken. Pixels of the next measurement keep flowing meanwhile, but its own
// last pixel waits at the queue head until the divider is free again. The
// coefficient tables come up undefined and are not cleared; configuration
// resets to the full frame and unity scale.
module roi_radiometric_statistics_core #(
   parameter int ROWS = 512,
   parameter int COLS = 1024
) (
   input logic       clock,
   input logic       reset,
   rrs_req_if.sink   req_chan,
   rrs_rsp_if.source rsp_chan,
   rrs_csr_if.sink   csr_chan
);

   rrs_pkg::cfg_type   cfg;
   rrs_pkg::entry_type push_entry;
   rrs_pkg::entry_type head;
   rrs_pkg::stats_type stats_snap;
   logic               push, queue_full, queue_not_empty, pop;
   logic               div_idle, stats_start;

   rrs_front #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry),
      .cfg        (cfg)
   );

   rrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   rrs_back #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .queue_not_empty (queue_not_empty),
      .head            (head),
      .pop             (pop),
      .div_idle        (div_idle),
      .stats_start     (stats_start),
      .stats_snap      (stats_snap)
   );

   rrs_stats_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (stats_start),
      .snap     (stats_snap),
      .idle     (div_idle),
      .rsp_chan (rsp_chan)
   );

endmodule

### hw/rtl/rrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/rrs_front.sv
// Front end: configuration registers, beat acceptance and classification.
module rrs_front #(
   parameter int ROWS = 512,
   parameter int COLS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   rrs_req_if.sink             req_chan,
   rrs_csr_if.sink             csr_chan,
   input  logic                queue_full,
   output logic                push,
   output rrs_pkg::entry_type  push_entry,
   output rrs_pkg::cfg_type    cfg
);

   rrs_pkg::cfg_type cfg_ff;
   rrs_pkg::cfg_type cfg_in;
   logic             is_measure;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (rrs_pkg::csr_index_type'(csr_chan.index))
            rrs_pkg::CSR_ROI_TOP:    cfg_in.roi_top      = csr_chan.data[rrs_pkg::ROW_W-1:0];
            rrs_pkg::CSR_ROI_LEFT:   cfg_in.roi_left     = csr_chan.data[rrs_pkg::COL_W-1:0];
            rrs_pkg::CSR_ROI_BOTTOM: cfg_in.roi_bottom   = csr_chan.data[rrs_pkg::ROW_W-1:0];
            rrs_pkg::CSR_ROI_RIGHT:  cfg_in.roi_right    = csr_chan.data[rrs_pkg::COL_W-1:0];
            rrs_pkg::CSR_SCALE:      cfg_in.scale_factor = csr_chan.data[rrs_pkg::SCALE_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.roi_top      <= rrs_pkg::ROI_TOP_RST;
         cfg_ff.roi_left     <= rrs_pkg::ROI_LEFT_RST;
         cfg_ff.roi_bottom   <= rrs_pkg::ROI_BOTTOM_RST;
         cfg_ff.roi_right    <= rrs_pkg::ROI_RIGHT_RST;
         cfg_ff.scale_factor <= rrs_pkg::SCALE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;
   assign is_measure     = (req_chan.op == rrs_pkg::OP_MEASURE);

   always_comb begin
      push_entry.is_measure  = is_measure;
      push_entry.in_array    = (int'(req_chan.row) < ROWS) && (int'(req_chan.col) < COLS);
      push_entry.in_roi      = (req_chan.row >= cfg_ff.roi_top)  &&
                               (req_chan.row <= cfg_ff.roi_bottom) &&
                               (req_chan.col >= cfg_ff.roi_left) &&
                               (req_chan.col <= cfg_ff.roi_right);
      // last on a load beat means nothing
      push_entry.last        = req_chan.last && is_measure;
      push_entry.row         = req_chan.row;
      push_entry.col         = req_chan.col;
      push_entry.pixel_count = req_chan.pixel_count;
      push_entry.gain        = req_chan.gain;
      push_entry.offset      = req_chan.offset;
      push_entry.coeff_valid = req_chan.coeff_valid;
   end

endmodule

### hw/rtl/rrs_queue.sv
// Short FIFO of classified beats between the front and back ends.
module rrs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rrs_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output rrs_pkg::entry_type  head
);

   localparam int PTR_W = $clog2(rrs_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(rrs_pkg::QUEUE_DEPTH + 1);

   rrs_pkg::entry_type slot_ff [rrs_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   fill_ff;

   assign full      = (fill_ff == CNT_W'(rrs_pkg::QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         case ({push, pop})
            2'b10:   fill_ff <= fill_ff + CNT_W'(1);
            2'b01:   fill_ff <= fill_ff - CNT_W'(1);
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

### hw/rtl/rrs_back.sv
// Back end: coefficient tables, calibration pipeline and running statistics.
module rrs_back #(
   parameter int ROWS = 512,
   parameter int COLS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  rrs_pkg::cfg_type    cfg,
   input  logic                queue_not_empty,
   input  rrs_pkg::entry_type  head,
   output logic                pop,
   input  logic                div_idle,
   output logic                stats_start,
   output rrs_pkg::stats_type  stats_snap
);

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // table access
   logic [AW-1:0]                 addr;
   logic                          wr_en;
   logic [rrs_pkg::COEF_W:0]      gain_rd;
   logic [rrs_pkg::COEF_W-1:0]    offset_rd;
   logic                          last_in_pipe;

   // pipeline control
   rrs_pkg::ctl_type s1_ctl_ff, s2_ctl_ff, s3_ctl_ff, s4_ctl_ff, s5_ctl_ff, s6_ctl_ff;
   rrs_pkg::ctl_type s1_ctl_in;

   // pipeline payload
   logic [rrs_pkg::CNT_W-1:0]          s1_cnt_ff;
   logic signed [rrs_pkg::PROD_W-1:0]  s2_prod_ff;
   logic signed [rrs_pkg::COEF_W-1:0]  s2_off_ff;
   logic signed [rrs_pkg::PROD_W-1:0]  s3_v_ff;
   logic [rrs_pkg::PROD_W-1:0]         s4_plo_ff;
   logic signed [rrs_pkg::PROD_W-1:0]  s4_phi_ff;
   logic signed [rrs_pkg::QS_W-1:0]    s5_q_ff;
   logic                               s5_sat_hi_ff;
   logic                               s5_sat_lo_ff;
   logic signed [rrs_pkg::RAD_W-1:0]   s6_r_ff;

   logic signed [rrs_pkg::COEF_W-1:0]  gain_s;
   logic signed [rrs_pkg::CNT_W:0]     cnt_s;
   logic signed [rrs_pkg::PROD_W-1:0]  prod_in;
   logic signed [rrs_pkg::PROD_W-1:0]  v_in;
   logic [rrs_pkg::VLO_W-1:0]          v_lo;
   logic signed [rrs_pkg::VHI_W-1:0]   v_hi;
   logic signed [rrs_pkg::SCALE_W:0]   scale_s;
   logic [rrs_pkg::PROD_W-1:0]         plo_in;
   logic signed [rrs_pkg::PROD_W-1:0]  phi_in;
   logic signed [rrs_pkg::FULL_W-1:0]  full_w;
   logic signed [rrs_pkg::Q_W-1:0]     q_w;
   logic signed [rrs_pkg::RAD_W-1:0]   r_in;

   // accumulators
   logic signed [rrs_pkg::RAD_W-1:0]   max_ff, max_in;
   logic signed [rrs_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [rrs_pkg::NPIX_W-1:0]         count_ff, count_in;
   logic signed [rrs_pkg::SUM_W:0]     sum_wide;

   assign last_in_pipe = (s1_ctl_ff.valid && s1_ctl_ff.last) || (s2_ctl_ff.valid && s2_ctl_ff.last) ||
                         (s3_ctl_ff.valid && s3_ctl_ff.last) || (s4_ctl_ff.valid && s4_ctl_ff.last) ||
                         (s5_ctl_ff.valid && s5_ctl_ff.last) || (s6_ctl_ff.valid && s6_ctl_ff.last);

   // a closing pixel waits until the divider can take its snapshot
   assign pop   = queue_not_empty && (!head.last || (!last_in_pipe && div_idle));
   assign addr  = AW'(int'(head.row) * COLS + int'(head.col));
   assign wr_en = pop && !head.is_measure && head.in_array;

   rrs_ram #(
      .WIDTH (rrs_pkg::COEF_W + 1),
      .DEPTH (DEPTH)
   ) u_gain_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data ({head.coeff_valid, head.gain}),
      .rd_addr (addr),
      .rd_data (gain_rd)
   );

   rrs_ram #(
      .WIDTH (rrs_pkg::COEF_W),
      .DEPTH (DEPTH)
   ) u_offset_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (head.offset),
      .rd_addr (addr),
      .rd_data (offset_rd)
   );

   always_comb begin
      s1_ctl_in.valid = pop && head.is_measure;
      s1_ctl_in.last  = head.last;
      s1_ctl_in.take  = head.in_array && head.in_roi;
   end

   // stage 1: gain * count
   assign gain_s  = signed'(gain_rd[rrs_pkg::COEF_W-1:0]);
   assign cnt_s   = signed'({1'b0, s1_cnt_ff});
   assign prod_in = gain_s * cnt_s;

   // stage 2: add offset
   assign v_in = s2_prod_ff + rrs_pkg::PROD_W'(s2_off_ff);

   // stage 3: v * scale as two partial products
   assign v_lo    = s3_v_ff[rrs_pkg::VLO_W-1:0];
   assign v_hi    = signed'(s3_v_ff[rrs_pkg::PROD_W-1:rrs_pkg::VLO_W]);
   assign scale_s = signed'({1'b0, cfg.scale_factor});
   assign plo_in  = rrs_pkg::PROD_W'(v_lo) * rrs_pkg::PROD_W'(cfg.scale_factor);
   assign phi_in  = v_hi * scale_s;

   // stage 4: recombine, floor shift by 16
   assign full_w = (rrs_pkg::FULL_W'(s4_phi_ff) << rrs_pkg::VLO_W) +
                   signed'(rrs_pkg::FULL_W'(s4_plo_ff));
   assign q_w    = full_w[rrs_pkg::FULL_W-1:16];

   // stage 5: scale by 100 or saturate
   always_comb begin
      if (s5_sat_hi_ff) begin
         r_in = rrs_pkg::RAD_MAX;
      end else if (s5_sat_lo_ff) begin
         r_in = rrs_pkg::RAD_MIN;
      end else begin
         r_in = rrs_pkg::RAD_W'(s5_q_ff) * rrs_pkg::RAD_SCALE;
      end
   end

   always_ff @(posedge clock) begin
      s1_cnt_ff    <= head.pixel_count;
      s2_prod_ff   <= prod_in;
      s2_off_ff    <= signed'(offset_rd);
      s3_v_ff      <= v_in;
      s4_plo_ff    <= plo_in;
      s4_phi_ff    <= phi_in;
      s5_q_ff      <= q_w[rrs_pkg::QS_W-1:0];
      s5_sat_hi_ff <= (q_w > rrs_pkg::Q_LIMIT);
      s5_sat_lo_ff <= (q_w < -rrs_pkg::Q_LIMIT);
      s6_r_ff      <= r_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
         s4_ctl_ff <= '0;
         s5_ctl_ff <= '0;
         s6_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= '{valid: s1_ctl_ff.valid, last: s1_ctl_ff.last,
                        take:  s1_ctl_ff.take && gain_rd[rrs_pkg::COEF_W]};
         s3_ctl_ff <= s2_ctl_ff;
         s4_ctl_ff <= s3_ctl_ff;
         s5_ctl_ff <= s4_ctl_ff;
         s6_ctl_ff <= s5_ctl_ff;
      end
   end

   // stage 6: running statistics
   assign sum_wide = {sum_ff[rrs_pkg::SUM_W-1], sum_ff} + (rrs_pkg::SUM_W + 1)'(s6_r_ff);

   always_comb begin
      max_in   = max_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      if (s6_ctl_ff.valid && s6_ctl_ff.take) begin
         if (s6_r_ff > max_ff) begin
            max_in = s6_r_ff;
         end
         if (sum_wide[rrs_pkg::SUM_W] != sum_wide[rrs_pkg::SUM_W-1]) begin
            sum_in = sum_wide[rrs_pkg::SUM_W] ? rrs_pkg::SUM_MIN : rrs_pkg::SUM_MAX;
         end else begin
            sum_in = sum_wide[rrs_pkg::SUM_W-1:0];
         end
         if (count_ff != rrs_pkg::COUNT_MAX) begin
            count_in = count_ff + rrs_pkg::NPIX_W'(1);
         end
      end
   end

   assign stats_start             = s6_ctl_ff.valid && s6_ctl_ff.last;
   assign stats_snap.max_radiance = max_in;
   assign stats_snap.sum_radiance = sum_in;
   assign stats_snap.valid_pixels = count_in;

   always_ff @(posedge clock) begin
      if (reset || stats_start) begin
         max_ff   <= rrs_pkg::RAD_MIN;
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         max_ff   <= max_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

### hw/rtl/rrs_stats_div.sv
// Statistics close-out: serial mean division and the result register.
module rrs_stats_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  rrs_pkg::stats_type  snap,
   output logic                idle,
   rrs_rsp_if.source           rsp_chan
);

   localparam int BIT_W = $clog2(rrs_pkg::SUM_W);

   rrs_pkg::div_state_type state_ff, state_in;

   logic load_en, step_en, fin_en;

   logic signed [rrs_pkg::RAD_W-1:0] max_ff;
   logic signed [rrs_pkg::SUM_W-1:0] sum_ff;
   logic [rrs_pkg::NPIX_W-1:0]       count_ff;
   logic                             neg_ff;
   logic [rrs_pkg::SUM_W-1:0]        num_ff;
   logic [rrs_pkg::NPIX_W-1:0]       rem_ff;
   logic [BIT_W-1:0]                 bit_ff;
   logic [rrs_pkg::RAD_W-1:0]        mean_ff, mean_in;

   logic [rrs_pkg::NPIX_W:0]         trial;
   logic                             ge;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrs_pkg::DIV_IDLE: begin
            if (start) state_in = rrs_pkg::DIV_RUN;
         end
         rrs_pkg::DIV_RUN: begin
            if (bit_ff == '0) state_in = rrs_pkg::DIV_FIN;
         end
         rrs_pkg::DIV_FIN: begin
            state_in = rrs_pkg::DIV_SHOW;
         end
         rrs_pkg::DIV_SHOW: begin
            if (rsp_chan.ready) state_in = rrs_pkg::DIV_IDLE;
         end
         default: begin
            state_in = rrs_pkg::DIV_IDLE;
         end
      endcase
   end

   always_comb begin
      idle           = 1'b0;
      load_en        = 1'b0;
      step_en        = 1'b0;
      fin_en         = 1'b0;
      rsp_chan.valid = 1'b0;
      case (state_ff)
         rrs_pkg::DIV_IDLE: begin
            idle    = 1'b1;
            load_en = start;
         end
         rrs_pkg::DIV_RUN: begin
            step_en = 1'b1;
         end
         rrs_pkg::DIV_FIN: begin
            fin_en = 1'b1;
         end
         rrs_pkg::DIV_SHOW: begin
            rsp_chan.valid = 1'b1;
         end
         default: begin
            idle = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrs_pkg::DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // restoring division on the magnitude, one quotient bit a cycle
   assign trial = {rem_ff, num_ff[rrs_pkg::SUM_W-1]};
   assign ge    = (trial >= {1'b0, count_ff});

   always_comb begin
      if (count_ff == '0) begin
         mean_in = '0;
      end else if (neg_ff) begin
         mean_in = (num_ff > rrs_pkg::MEAN_NEG_LIM) ? rrs_pkg::RAD_MIN :
                   -num_ff[rrs_pkg::RAD_W-1:0];
      end else begin
         mean_in = (num_ff > rrs_pkg::MEAN_POS_LIM) ? rrs_pkg::RAD_MAX :
                   num_ff[rrs_pkg::RAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         // no pixels: every field reads zero
         max_ff   <= (snap.valid_pixels == '0) ? '0 : snap.max_radiance;
         sum_ff   <= snap.sum_radiance;
         count_ff <= snap.valid_pixels;
         neg_ff   <= snap.sum_radiance[rrs_pkg::SUM_W-1];
         num_ff   <= snap.sum_radiance[rrs_pkg::SUM_W-1] ? -snap.sum_radiance :
                     snap.sum_radiance;
         rem_ff   <= '0;
         bit_ff   <= BIT_W'(rrs_pkg::SUM_W - 1);
      end
      if (step_en) begin
         rem_ff <= ge ? rrs_pkg::NPIX_W'(trial - {1'b0, count_ff}) :
                   trial[rrs_pkg::NPIX_W-1:0];
         num_ff <= {num_ff[rrs_pkg::SUM_W-2:0], ge};
         bit_ff <= bit_ff - BIT_W'(1);
      end
      if (fin_en) begin
         mean_ff <= mean_in;
      end
   end

   assign rsp_chan.max_radiance  = max_ff;
   assign rsp_chan.mean_radiance = signed'(mean_ff);
   assign rsp_chan.sum_radiance  = sum_ff;
   assign rsp_chan.valid_pixels  = count_ff;

endmodule

### hw/rtl/rrs_checker.sv
// Port-level checks of the result channel, bound to the core.
module rrs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [rrs_pkg::RAD_W-1:0] rsp_max_radiance,
   input logic signed [rrs_pkg::RAD_W-1:0] rsp_mean_radiance,
   input logic signed [rrs_pkg::SUM_W-1:0] rsp_sum_radiance,
   input logic [rrs_pkg::NPIX_W-1:0]       rsp_valid_pixels
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_max_radiance) && $stable(rsp_mean_radiance) &&
                                  $stable(rsp_sum_radiance) && $stable(rsp_valid_pixels))
      else $error("stalled result beat changed");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_pixels == '0 |->
         rsp_max_radiance == '0 && rsp_mean_radiance == '0 && rsp_sum_radiance == '0)
      else $error("empty measurement gave non-zero statistics");

   a_mean_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_pixels != '0 |->
         (rsp_sum_radiance[rrs_pkg::SUM_W-1] ? (rsp_mean_radiance <= 0)
                                             : !rsp_mean_radiance[rrs_pkg::RAD_W-1]))
      else $error("mean sign disagrees with sum");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat shown straight after reset");

endmodule

bind roi_radiometric_statistics_core rrs_checker u_rrs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_max_radiance  (rsp_chan.max_radiance),
   .rsp_mean_radiance (rsp_chan.mean_radiance),
   .rsp_sum_radiance  (rsp_chan.sum_radiance),
   .rsp_valid_pixels  (rsp_chan.valid_pixels)
);
